[rtl/core/ppss_pkg.sv]
// Shared constants, operation codes and types for the priority slot scheduler.
package ppss_pkg;

    localparam int SLOTS_DEF     = 4;
    localparam int PRIO_BITS_DEF = 3;

    localparam int OP_W   = 2;
    localparam int TIME_W = 32;
    localparam int MOOD_W = 4;
    localparam int DUR_W  = 16;
    localparam int PRIO_W = 3;

    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

    localparam logic [PRIO_W-1:0] FLUSH_RESET = 3'd2;

    typedef struct packed {
        logic is_request;
        logic flush_en;
    } scan_ctrl_t;

endpackage

[rtl/core/ppss_scan.sv]
// Slot scan unit: walks the wait slots one per cycle with a shared priority compare.
module ppss_scan
    import ppss_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int PW    = PRIO_BITS_DEF,
    localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          step,
    input  scan_ctrl_t    ctrl,
    input  logic [PW-1:0] ref_prio,
    input  logic          rd_valid,
    input  logic [PW-1:0] rd_prio,
    output logic [IW-1:0] idx,
    output logic          last,
    output logic          drop,
    output logic          best_upd,
    output logic          free_found,
    output logic [IW-1:0] free_idx,
    output logic [IW-1:0] weak_idx,
    output logic [PW-1:0] weak_prio,
    output logic          best_found,
    output logic [IW-1:0] best_idx,
    output logic [PW-1:0] best_prio
);

    logic [IW-1:0] idx_reg;
    logic          free_found_reg;
    logic [IW-1:0] free_idx_reg;
    logic [IW-1:0] weak_idx_reg;
    logic [PW-1:0] weak_prio_reg;
    logic          best_found_reg;
    logic [IW-1:0] best_idx_reg;
    logic [PW-1:0] best_prio_reg;

    logic live;
    logic take_free;
    logic take_weak;

    always_comb
    begin
        // drop a lower-priority waiting job ahead of a flushing request
        drop      = step && ctrl.flush_en && rd_valid && (rd_prio < ref_prio);
        live      = rd_valid && !drop;
        take_free = step && ctrl.is_request && !free_found_reg && !live;
        take_weak = step && ctrl.is_request && ((idx_reg == '0) || (rd_prio < weak_prio_reg));
        best_upd  = step && !ctrl.is_request && rd_valid
                    && (!best_found_reg || (rd_prio > best_prio_reg));
        last      = (idx_reg == IW'(SLOTS - 1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            weak_idx_reg   <= '0;
            weak_prio_reg  <= '0;
            best_found_reg <= 1'b0;
            best_idx_reg   <= '0;
            best_prio_reg  <= '0;
        end
        else if (start)
        begin
            idx_reg        <= '0;
            free_found_reg <= 1'b0;
            best_found_reg <= 1'b0;
        end
        else if (step)
        begin
            if (!last)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (take_free)
            begin
                free_found_reg <= 1'b1;
                free_idx_reg   <= idx_reg;
            end
            if (take_weak)
            begin
                weak_idx_reg  <= idx_reg;
                weak_prio_reg <= rd_prio;
            end
            if (best_upd)
            begin
                best_found_reg <= 1'b1;
                best_idx_reg   <= idx_reg;
                best_prio_reg  <= rd_prio;
            end
        end
    end

    assign idx        = idx_reg;
    assign free_found = free_found_reg;
    assign free_idx   = free_idx_reg;
    assign weak_idx   = weak_idx_reg;
    assign weak_prio  = weak_prio_reg;
    assign best_found = best_found_reg;
    assign best_idx   = best_idx_reg;
    assign best_prio  = best_prio_reg;

endmodule

[rtl/core/preemptive_priority_slot_scheduler.sv]
// Top level: preemptive priority scheduler with one running job and a bounded wait queue.
// Request and tick words go through the slot scan, which visits one wait slot per cycle,
// then the finish step, which registers the result; clear and unused ops go straight to finish.
// The finish step waits while the result output is stalled. A new word is taken only once
// the previous one has left the finish step and the block is idle again.
// Reset: no current job, all slots empty, flush level 2, no result pending.
module preemptive_priority_slot_scheduler
    import ppss_pkg::*;
#(
    parameter int SLOTS     = SLOTS_DEF,
    parameter int PRIO_BITS = PRIO_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // configuration: flush level
    input  logic              cfg_we,
    input  logic [PRIO_W-1:0] cfg_wdata,
    // input words
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [OP_W-1:0]   op,
    input  logic [TIME_W-1:0] now,
    input  logic [MOOD_W-1:0] mood,
    input  logic [DUR_W-1:0]  duration,
    input  logic [PRIO_W-1:0] priority_req,
    input  logic              explicit_flag,
    input  logic              queue_if_blocked,
    // result words
    output logic              out_valid,
    input  logic              out_stall,
    output logic              accepted,
    output logic              cur_valid,
    output logic [MOOD_W-1:0] cur_mood,
    output logic [PRIO_W-1:0] cur_priority,
    output logic              cur_explicit,
    output logic [TIME_W-1:0] cur_start,
    output logic [DUR_W-1:0]  cur_duration
);

    // priorities live in at most the port width
    localparam int PW = (PRIO_BITS < PRIO_W) ? PRIO_BITS : PRIO_W;
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_FINISH} state_t;

    state_t state_reg;
    state_t state_next;

    logic [PW-1:0] flush_prio_reg;

    // latched input word
    logic [OP_W-1:0]   req_op_reg;
    logic [TIME_W-1:0] req_now_reg;
    logic [MOOD_W-1:0] req_mood_reg;
    logic [DUR_W-1:0]  req_dur_reg;
    logic [PW-1:0]     req_prio_reg;
    logic              req_expl_reg;
    logic              req_queue_reg;

    // running job; end time is kept alongside so the activity test is one subtract
    logic              cur_valid_reg;
    logic [MOOD_W-1:0] cur_mood_reg;
    logic [PW-1:0]     cur_prio_reg;
    logic              cur_expl_reg;
    logic [TIME_W-1:0] cur_start_reg;
    logic [DUR_W-1:0]  cur_dur_reg;
    logic [TIME_W-1:0] cur_end_reg;

    logic              cur_valid_next;
    logic [MOOD_W-1:0] cur_mood_next;
    logic [PW-1:0]     cur_prio_next;
    logic              cur_expl_next;
    logic [TIME_W-1:0] cur_start_next;
    logic [DUR_W-1:0]  cur_dur_next;
    logic [TIME_W-1:0] cur_end_next;

    // wait slots: valid bits in reset flops, payload without reset
    logic [SLOTS-1:0]  slot_valid_reg;
    logic [SLOTS-1:0]  slot_valid_next;
    logic [MOOD_W-1:0] slot_mood_reg [SLOTS];
    logic [PW-1:0]     slot_prio_reg [SLOTS];
    logic              slot_expl_reg [SLOTS];
    logic [DUR_W-1:0]  slot_dur_reg  [SLOTS];

    // payload of the best waiting job, captured during the scan
    logic [MOOD_W-1:0] best_mood_reg;
    logic              best_expl_reg;
    logic [DUR_W-1:0]  best_dur_reg;

    logic              active_reg;
    logic              active_next;
    logic [TIME_W-1:0] age_diff;

    // result register
    logic              out_valid_reg;
    logic              res_acc_reg;
    logic              res_valid_reg;
    logic [MOOD_W-1:0] res_mood_reg;
    logic [PRIO_W-1:0] res_prio_reg;
    logic              res_expl_reg;
    logic [TIME_W-1:0] res_start_reg;
    logic [DUR_W-1:0]  res_dur_reg;

    // scan unit
    scan_ctrl_t        scan_ctrl;
    logic              scan_step;
    logic [IW-1:0]     scan_idx;
    logic              scan_last;
    logic              scan_drop;
    logic              best_upd;
    logic              free_found;
    logic [IW-1:0]     free_idx;
    logic [IW-1:0]     weak_idx;
    logic [PW-1:0]     weak_prio;
    logic              best_found;
    logic [IW-1:0]     best_idx;
    logic [PW-1:0]     best_prio;

    // finish decisions
    logic              in_accept;
    logic              can_out;
    logic              finish_fire;
    logic              preempt;
    logic              acc_next;
    logic              cur_load;
    logic              cur_drop;
    logic              load_from_slot;
    logic              slot_wr;
    logic [IW-1:0]     slot_wr_idx;
    logic              slot_take;
    logic              clear_all;
    logic [MOOD_W-1:0] ld_mood;
    logic [PW-1:0]     ld_prio;
    logic              ld_expl;
    logic [DUR_W-1:0]  ld_dur;

    assign in_accept   = in_valid && !in_stall;
    assign in_stall    = (state_reg != S_IDLE);
    assign can_out     = !out_valid_reg || !out_stall;
    assign finish_fire = (state_reg == S_FINISH) && can_out;
    assign scan_step   = (state_reg == S_SCAN);

    assign scan_ctrl.is_request = (req_op_reg == OP_REQUEST);
    assign scan_ctrl.flush_en   = (req_op_reg == OP_REQUEST) && (req_prio_reg >= flush_prio_reg);

    ppss_scan #(
        .SLOTS (SLOTS),
        .PW    (PW)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_accept),
        .step       (scan_step),
        .ctrl       (scan_ctrl),
        .ref_prio   (req_prio_reg),
        .rd_valid   (slot_valid_reg[scan_idx]),
        .rd_prio    (slot_prio_reg[scan_idx]),
        .idx        (scan_idx),
        .last       (scan_last),
        .drop       (scan_drop),
        .best_upd   (best_upd),
        .free_found (free_found),
        .free_idx   (free_idx),
        .weak_idx   (weak_idx),
        .weak_prio  (weak_prio),
        .best_found (best_found),
        .best_idx   (best_idx),
        .best_prio  (best_prio)
    );

    // the running job stays active while now has not reached its end time
    assign age_diff    = req_now_reg - cur_end_reg;
    assign active_next = cur_valid_reg && age_diff[TIME_W-1];
    assign preempt     = !active_reg || (req_prio_reg >= cur_prio_reg);

    // decide what the finishing step does
    always_comb
    begin
        acc_next       = 1'b0;
        cur_load       = 1'b0;
        cur_drop       = 1'b0;
        load_from_slot = 1'b0;
        slot_wr        = 1'b0;
        slot_wr_idx    = free_idx;
        slot_take      = 1'b0;
        clear_all      = 1'b0;
        case (req_op_reg)
            OP_REQUEST:
            begin
                if (preempt)
                begin
                    cur_load = 1'b1;
                    acc_next = 1'b1;
                end
                else if (req_queue_reg)
                begin
                    if (free_found)
                    begin
                        slot_wr  = 1'b1;
                        acc_next = 1'b1;
                    end
                    else if (req_prio_reg > weak_prio)
                    begin
                        // evict the weakest waiting job
                        slot_wr     = 1'b1;
                        slot_wr_idx = weak_idx;
                        acc_next    = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (!active_reg)
                begin
                    cur_drop = 1'b1;
                    if (best_found)
                    begin
                        cur_load       = 1'b1;
                        load_from_slot = 1'b1;
                        slot_take      = 1'b1;
                        acc_next       = 1'b1;
                    end
                end
            end
            OP_CLEAR:
            begin
                cur_drop  = 1'b1;
                clear_all = 1'b1;
            end
            default:
            begin
                acc_next = 1'b0;
            end
        endcase

        ld_mood = load_from_slot ? best_mood_reg : req_mood_reg;
        ld_prio = load_from_slot ? best_prio     : req_prio_reg;
        ld_expl = load_from_slot ? best_expl_reg : req_expl_reg;
        ld_dur  = load_from_slot ? best_dur_reg  : req_dur_reg;

        cur_valid_next = cur_load ? 1'b1 : (cur_drop ? 1'b0 : cur_valid_reg);
        cur_mood_next  = cur_load ? ld_mood     : cur_mood_reg;
        cur_prio_next  = cur_load ? ld_prio     : cur_prio_reg;
        cur_expl_next  = cur_load ? ld_expl     : cur_expl_reg;
        cur_start_next = cur_load ? req_now_reg : cur_start_reg;
        cur_dur_next   = cur_load ? ld_dur      : cur_dur_reg;
        cur_end_next   = req_now_reg + TIME_W'(ld_dur);
    end

    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        if (scan_drop)
        begin
            slot_valid_next[scan_idx] = 1'b0;
        end
        if (finish_fire)
        begin
            if (clear_all)
            begin
                slot_valid_next = '0;
            end
            else if (slot_wr)
            begin
                slot_valid_next[slot_wr_idx] = 1'b1;
            end
            else if (slot_take)
            begin
                slot_valid_next[best_idx] = 1'b0;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // only requests and ticks need the slot scan
                    if ((op == OP_REQUEST) || (op == OP_TICK))
                    begin
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (can_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            flush_prio_reg <= FLUSH_RESET[PW-1:0];
            cur_valid_reg  <= 1'b0;
            slot_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            if (cfg_we)
            begin
                flush_prio_reg <= cfg_wdata[PW-1:0];
            end
            if (finish_fire)
            begin
                cur_valid_reg <= cur_valid_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            req_op_reg    <= op;
            req_now_reg   <= now;
            req_mood_reg  <= mood;
            req_dur_reg   <= duration;
            req_prio_reg  <= priority_req[PW-1:0];
            req_expl_reg  <= explicit_flag;
            req_queue_reg <= queue_if_blocked;
        end
        if (scan_step)
        begin
            active_reg <= active_next;
        end
        if (best_upd)
        begin
            best_mood_reg <= slot_mood_reg[scan_idx];
            best_expl_reg <= slot_expl_reg[scan_idx];
            best_dur_reg  <= slot_dur_reg[scan_idx];
        end
        if (finish_fire)
        begin
            cur_mood_reg  <= cur_mood_next;
            cur_prio_reg  <= cur_prio_next;
            cur_expl_reg  <= cur_expl_next;
            cur_start_reg <= cur_start_next;
            cur_dur_reg   <= cur_dur_next;
            if (cur_load)
            begin
                cur_end_reg <= cur_end_next;
            end
            if (slot_wr)
            begin
                slot_mood_reg[slot_wr_idx] <= req_mood_reg;
                slot_prio_reg[slot_wr_idx] <= req_prio_reg;
                slot_expl_reg[slot_wr_idx] <= req_expl_reg;
                slot_dur_reg[slot_wr_idx]  <= req_dur_reg;
            end
            // show the job state after the step; zero fields when idle
            res_acc_reg   <= acc_next;
            res_valid_reg <= cur_valid_next;
            res_mood_reg  <= cur_valid_next ? cur_mood_next : '0;
            res_prio_reg  <= cur_valid_next ? PRIO_W'(cur_prio_next) : '0;
            res_expl_reg  <= cur_valid_next && cur_expl_next;
            res_start_reg <= cur_valid_next ? cur_start_next : '0;
            res_dur_reg   <= cur_valid_next ? cur_dur_next : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = res_acc_reg;
    assign cur_valid    = res_valid_reg;
    assign cur_mood     = res_mood_reg;
    assign cur_priority = res_prio_reg;
    assign cur_explicit = res_expl_reg;
    assign cur_start    = res_start_reg;
    assign cur_duration = res_dur_reg;

    // an accepted word always leaves a running job behind
    a_accept_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> cur_valid)
        else $error("accepted result without a running job");

    // with no running job every job field reads zero
    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !cur_valid) |-> ((cur_start == '0) && (cur_duration == '0)
            && (cur_mood == '0) && (cur_priority == '0) && !cur_explicit))
        else $error("job fields not zero while no job is held");

    // clear empties the queue and the running job
    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (finish_fire && (req_op_reg == OP_CLEAR)) |=> ((slot_valid_reg == '0) && !cur_valid_reg))
        else $error("clear left a job behind");

    // the scan ends after the last slot
    a_scan_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (scan_step && scan_last) |=> (state_reg == S_FINISH))
        else $error("scan did not hand over to finish");

endmodule
